@@ rtl/bpa_pkg.sv @@
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam logic [31:0] ReservedBytes = 32'h0020_0000;
  localparam logic [31:0] ResetTotalMem = 32'd33554432;
  localparam logic [31:0] ResetHeapBase = 32'hC010_0000;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StBadCount = 3'd1;
  localparam logic [2:0] StUser     = 3'd2;
  localparam logic [2:0] StNoRun    = 3'd3;
  localparam logic [2:0] StPhysOut  = 3'd4;

  localparam logic RegTotalMem = 1'b0;
  localparam logic RegHeapBase = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_VREAD,
    S_VSCAN,
    S_VMARK,
    S_PREAD,
    S_PSCAN,
    S_EMIT,
    S_ERR
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;   // clear word at sweep address, advance
    logic load_req;     // latch request, reset scan
    logic vscan_step;   // test current virtual bit, advance
    logic vmark_step;   // mark one virtual bit of the run
    logic pscan_step;   // test current physical bit, advance
    logic pmark;        // mark found frame, emit good result
    logic emit_err;     // emit an error result
    logic [2:0] err_code;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic bad_count;
    logic vfound;       // run complete at current bit
    logic vend;         // scan reached pool end
    logic mark_done;    // last run bit marked
    logic pfree;        // current physical bit free
    logic pend;         // physical scan reached pool end
    logic last_page;    // page being allocated is the last
  } stat_t;

endpackage

@@ rtl/bpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer of the allocator: clear sweep, run search, marking, frame search.
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           func_i,
  input  bpa_pkg::stat_t stat_i,
  output bpa_pkg::cmd_t  cmd_o,
  output logic           busy_o
);
  import bpa_pkg::*;

  state_e state_q, state_d;
  logic [2:0] err_q, err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      err_q   <= StOk;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
    end
  end

  always_comb begin
    state_d = state_q;
    err_d   = err_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (stat_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load_req = 1'b1;
          state_d = S_VREAD;
        end
      end
      S_VREAD: begin
        // Request latched; classify it.
        if (stat_i.bad_count) begin
          err_d = StBadCount; state_d = S_ERR;
        end else if (func_i) begin
          err_d = StUser; state_d = S_ERR;
        end else begin
          state_d = S_VSCAN;
        end
      end
      S_VSCAN: begin
        if (stat_i.vend) begin
          err_d = StNoRun; state_d = S_ERR;
        end else begin
          cmd_o.vscan_step = 1'b1;
          if (stat_i.vfound) state_d = S_VMARK;
        end
      end
      S_VMARK: begin
        cmd_o.vmark_step = 1'b1;
        if (stat_i.mark_done) state_d = S_PREAD;
      end
      S_PREAD: state_d = S_PSCAN;
      S_PSCAN: begin
        if (stat_i.pend) begin
          err_d = StPhysOut; state_d = S_ERR;
        end else if (stat_i.pfree) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.pscan_step = 1'b1;
        end
      end
      S_EMIT: begin
        cmd_o.pmark = 1'b1;
        state_d = stat_i.last_page ? S_IDLE : S_PSCAN;
      end
      S_ERR: begin
        cmd_o.emit_err = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    cmd_o.err_code = err_q;
  end

endmodule

@@ rtl/bpa_datapath.sv @@
// ----------------------------------------------------------------------------
// bpa_datapath
// Bitmaps, pool size, scan pointers and result formation.
// ----------------------------------------------------------------------------
module bpa_datapath #(
  parameter int PoolPages = 4096,
  parameter int MaxRun    = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [11:0]    page_count_i,
  input  logic [31:0]    total_mem_q_i,
  input  logic [31:0]    heap_base_q_i,
  input  bpa_pkg::cmd_t  cmd_i,
  output bpa_pkg::stat_t stat_o,
  output logic           valid_o,
  output logic [31:0]    virtual_address_o,
  output logic [31:0]    physical_address_o,
  output logic [2:0]     status_o,
  output logic           last_result_o
);
  import bpa_pkg::*;

  localparam int IW = $clog2(PoolPages);
  localparam int CW = IW + 1;

  logic vmap_q [PoolPages];
  logic pmap_q [PoolPages];

  logic [CW-1:0] size_q;
  logic [CW-1:0] vidx_q, pidx_q, run_q, start_q, mark_q, page_q;
  logic [11:0]   count_q;
  logic          vbit_q, pbit_q;
  logic [CW-1:0] clr_q;

  // Pool size from installed memory: whole free pages halved, multiple of 8.
  logic [19:0] free_pages;
  logic [18:0] kpages;
  logic [CW-1:0] size_d;
  always_comb begin
    free_pages = (total_mem_q_i < ReservedBytes) ? 20'd0
                 : 20'((total_mem_q_i - ReservedBytes) >> 12);
    kpages = {free_pages[19:4], 3'b000};
    if (32'(kpages) > 32'(PoolPages)) size_d = CW'(PoolPages);
    else size_d = CW'(kpages);
  end

  logic [CW-1:0] cnt_ext;
  assign cnt_ext = (CW > 12) ? CW'(count_q) : CW'(count_q);
  logic [CW:0] run_inc;
  assign run_inc = {1'b0, run_q} + 1'b1;

  assign stat_o.clear_done = (clr_q == CW'(PoolPages - 1));
  assign stat_o.bad_count  = (count_q == 12'd0) || (32'(count_q) > 32'(MaxRun));
  assign stat_o.vend       = (vidx_q >= size_q);
  assign stat_o.vfound     = !vbit_q && (32'(run_inc) == 32'(count_q));
  assign stat_o.mark_done  = (32'(mark_q) + 1 == 32'(count_q));
  assign stat_o.pend       = (pidx_q >= size_q);
  assign stat_o.pfree      = !pbit_q;
  assign stat_o.last_page  = (32'(page_q) + 1 == 32'(count_q));

  logic [IW-1:0] vaddr, paddr;
  assign vaddr = cmd_i.vmark_step ? IW'(start_q + mark_q) : IW'(vidx_q);
  assign paddr = IW'(pidx_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step) begin
      vmap_q[IW'(clr_q)] <= 1'b0;
      pmap_q[IW'(clr_q)] <= 1'b0;
    end else begin
      if (cmd_i.vmark_step) vmap_q[vaddr] <= 1'b1;
      if (cmd_i.pmark) pmap_q[paddr] <= 1'b1;
    end
    vbit_q <= vmap_q[cmd_i.vscan_step ? IW'(vidx_q + 1'b1) : vaddr];
    pbit_q <= pmap_q[cmd_i.pscan_step || cmd_i.pmark ? IW'(pidx_q + 1'b1) : paddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      valid_o <= 1'b0;
    end else begin
      valid_o <= cmd_i.pmark || cmd_i.emit_err;
      if (cmd_i.clear_step) clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && cmd_i.load_req) begin
      count_q <= page_count_i;
      size_q  <= size_d;
      vidx_q  <= '0;
      pidx_q  <= '0;
      run_q   <= '0;
      mark_q  <= '0;
      page_q  <= '0;
    end
    if (cmd_i.vscan_step) begin
      vidx_q <= vidx_q + 1'b1;
      run_q  <= vbit_q ? '0 : CW'(run_inc);
      if (stat_o.vfound) start_q <= CW'(vidx_q + 1'b1 - cnt_ext);
    end
    if (cmd_i.vmark_step) mark_q <= mark_q + 1'b1;
    if (cmd_i.pscan_step || cmd_i.pmark) pidx_q <= pidx_q + 1'b1;
    if (cmd_i.pmark) begin
      page_q             <= page_q + 1'b1;
      virtual_address_o  <= heap_base_q_i + {20'(start_q + page_q), 12'h000};
      physical_address_o <= ReservedBytes + {20'(pidx_q), 12'h000};
      status_o           <= StOk;
      last_result_o      <= stat_o.last_page;
    end else if (cmd_i.emit_err) begin
      virtual_address_o  <= '0;
      physical_address_o <= '0;
      status_o           <= cmd_i.err_code;
      last_result_o      <= 1'b1;
    end
  end

endmodule

@@ rtl/bitmap_page_allocator_top.sv @@
// A request is classified, then the virtual bitmap is scanned for a run of free bits;
// the pages of the run are marked, then for each page a free frame is found in the
// physical bitmap and emitted. Scans test one map bit per cycle through each bitmap's single
// read port. Results come one per strobe cycle; the receiver cannot stall them.
// Reset: asynchronous, active low; a clearing sweep then zeroes both bitmaps
// while busy stays high. Configuration is taken at any time.
// ----------------------------------------------------------------------------
// bitmap_page_allocator_top
// First-fit kernel page allocator over a virtual and a physical bitmap.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_top #(
  parameter int POOL_PAGES = 4096,
  parameter int MAX_RUN    = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        func_i,
  input  logic [11:0] page_count_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [31:0] virtual_address_o,
  output logic [31:0] physical_address_o,
  output logic [2:0]  status_o,
  output logic        last_result_o
);
  import bpa_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic [31:0] total_mem_q, heap_base_q;
  logic        func_q;

  // Configuration writes are always accepted.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_mem_q <= ResetTotalMem;
      heap_base_q <= ResetHeapBase;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegTotalMem) total_mem_q <= cfg_data_i;
      else heap_base_q <= cfg_data_i;
    end
  end

  // The request's pool selector is held for the classification step.
  always_ff @(posedge clk_i) begin
    if (start && !busy) func_q <= func_i;
  end

  bpa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .func_i  (func_q),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  bpa_datapath #(
    .PoolPages (POOL_PAGES),
    .MaxRun    (MAX_RUN)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start),
    .page_count_i       (page_count_i),
    .total_mem_q_i      (total_mem_q),
    .heap_base_q_i      (heap_base_q),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .valid_o            (result_valid_o),
    .virtual_address_o  (virtual_address_o),
    .physical_address_o (physical_address_o),
    .status_o           (status_o),
    .last_result_o      (last_result_o)
  );

endmodule
